FILE: design/swfc_pkg.sv
// Shared types, constants and the CRC-8 function for the sensor word frame checker.
package swfc_pkg;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   localparam logic [14:0] TEMP_SCALE = 15'd17500;
   localparam logic [14:0] HUM_SCALE  = 15'd10000;
   localparam logic signed [16:0] TEMP_OFFSET = -17'sd4500;
   localparam logic [15:0] HUM_BAD_RAW = 16'hFFFF;

   localparam logic [1:0] IDX_CO2  = 2'd0;
   localparam logic [1:0] IDX_TEMP = 2'd1;
   localparam logic [1:0] IDX_HUM  = 2'd2;

   localparam logic [1:0] POS_HIGH = 2'd0;
   localparam logic [1:0] POS_LOW  = 2'd1;
   localparam logic [1:0] POS_CRC  = 2'd2;

   localparam logic REG_WORDS   = 1'b0;
   localparam logic REG_CONVERT = 1'b1;

   localparam logic [1:0] WORDS_RESET   = 2'd3;
   localparam logic       CONVERT_RESET = 1'b1;

   typedef struct packed {
      logic [15:0] raw;
      logic [1:0]  index;
      logic        convert;
      logic        crc_error;
   } scale_req_type;

   typedef struct packed {
      logic signed [16:0] scaled;
      logic               humidity_invalid;
   } scale_rsp_type;

   function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: design/swfc_if.sv
// Valid/ready channel interfaces for received bytes and checked words.
interface swfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface swfc_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        word_value;
   logic [1:0]         word_index;
   logic signed [16:0] scaled_value;
   logic               crc_error;
   logic               humidity_invalid;
   logic               frame_last;

   modport source (output valid, output word_value, output word_index, output scaled_value,
                   output crc_error, output humidity_invalid, output frame_last,
                   input ready);
   modport sink   (input valid, input word_value, input word_index, input scaled_value,
                   input crc_error, input humidity_invalid, input frame_last,
                   output ready);
endinterface

FILE: design/swfc_scale.sv
// Fixed-point conversion of a checked word to ppm, centidegrees or centipercent.
module swfc_scale (
   input  swfc_pkg::scale_req_type req,
   output swfc_pkg::scale_rsp_type rsp
);

   logic [14:0] factor;
   logic [30:0] product;
   logic [14:0] frac;

   assign factor  = (req.index == swfc_pkg::IDX_TEMP) ? swfc_pkg::TEMP_SCALE
                                                      : swfc_pkg::HUM_SCALE;
   assign product = 31'(factor) * 31'(req.raw);
   assign frac    = product[30:16];

   always_comb begin
      rsp.scaled           = signed'({1'b0, req.raw});
      rsp.humidity_invalid = 1'b0;
      if (req.crc_error) begin
         rsp.scaled = '0;
      end else if (req.convert) begin
         case (req.index)
            swfc_pkg::IDX_TEMP: begin
               rsp.scaled = swfc_pkg::TEMP_OFFSET + signed'({2'b00, frac});
            end
            swfc_pkg::IDX_HUM: begin
               if (req.raw == swfc_pkg::HUM_BAD_RAW) begin
                  rsp.scaled           = '0;
                  rsp.humidity_invalid = 1'b1;
               end else begin
                  rsp.scaled = signed'({2'b00, frac});
               end
            end
            default: begin
               rsp.scaled = signed'({1'b0, req.raw});
            end
         endcase
      end
   end

endmodule

FILE: design/sensor_word_frame_checker_top.sv
// Top level of the sensor word frame checker: byte input, CRC-8 check, word output.
// Takes one received byte per cycle; every third byte of an open frame is a
// CRC-8 checksum (poly 0x31, init 0xFF) over the two bytes before it, and gives
// one word item once the checksum byte has passed through the input register and
// then the result register. The result register decouples the sides, so a new byte is
// accepted in every cycle unless a finished word is still waiting and the byte in
// the input register would produce the next one. A checksum mismatch closes the
// frame; bytes are then dropped until one arrives with frame_start set.
// Registers: 0x0 words_in_frame (1..3, 0 acts as 1), 0x4 convert_measurement.
module sensor_word_frame_checker_top (
   input  logic                clock,
   input  logic                reset,
   swfc_req_if.sink            req_if,
   swfc_rsp_if.source          rsp_if,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   // configuration
   logic [1:0] words_ff, words_in;
   logic       convert_ff, convert_in;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      words_in   = words_ff;
      convert_in = convert_ff;
      if (csr_write) begin
         if (csr_paddr[2] == swfc_pkg::REG_WORDS) begin
            words_in = csr_pwdata[1:0];
         end else begin
            convert_in = csr_pwdata[0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == swfc_pkg::REG_WORDS) begin
         csr_prdata = {30'd0, words_ff};
      end else begin
         csr_prdata = {31'd0, convert_ff};
      end
   end

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       s1_start_ff, s1_start_in;
   logic       s1_go;
   logic       req_fire;

   // frame state
   logic [7:0] crc_ff, crc_in;
   logic [1:0] pos_ff, pos_in;
   logic [1:0] wc_ff, wc_in;
   logic [7:0] hi_ff, hi_in;
   logic [7:0] lo_ff, lo_in;
   logic       closed_ff, closed_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_word_ff, rsp_word_in;
   logic [1:0]         rsp_index_ff, rsp_index_in;
   logic signed [16:0] rsp_scaled_ff, rsp_scaled_in;
   logic               rsp_err_ff, rsp_err_in;
   logic               rsp_hum_ff, rsp_hum_in;
   logic               rsp_last_ff, rsp_last_in;

   // byte evaluation
   logic       live;
   logic [1:0] pos_eff;
   logic [7:0] crc_eff;
   logic [1:0] wc_eff;
   logic [7:0] crc_next;
   logic       makes_result;
   logic [15:0] raw;
   logic       err;
   logic [1:0] limit;
   logic       last;

   swfc_pkg::scale_req_type scale_req;
   swfc_pkg::scale_rsp_type scale_rsp;

   assign live     = s1_start_ff || !closed_ff;
   assign pos_eff  = s1_start_ff ? swfc_pkg::POS_HIGH : pos_ff;
   assign crc_eff  = s1_start_ff ? swfc_pkg::CRC_INIT : crc_ff;
   assign wc_eff   = s1_start_ff ? 2'd0 : wc_ff;
   assign crc_next = swfc_pkg::crc_feed(crc_eff, s1_byte_ff);
   assign makes_result = live && (pos_eff == swfc_pkg::POS_CRC);
   assign raw      = {hi_ff, lo_ff};
   assign err      = s1_byte_ff != crc_eff;
   assign limit    = (words_ff == 2'd0) ? 2'd1 : words_ff;
   assign last     = err || ((3'(wc_eff) + 3'd1) >= 3'(limit));

   assign s1_go    = s1_valid_ff && (!makes_result || !rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_go;
   assign req_fire = req_if.valid && req_if.ready;

   assign scale_req.raw       = raw;
   assign scale_req.index     = wc_eff;
   assign scale_req.convert   = convert_ff;
   assign scale_req.crc_error = err;

   swfc_scale u_scale (
      .req (scale_req),
      .rsp (scale_rsp)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_start_in = s1_start_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_if.rx_byte;
         s1_start_in = req_if.frame_start;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      crc_in    = crc_ff;
      pos_in    = pos_ff;
      wc_in     = wc_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      closed_in = closed_ff;
      if (s1_go && live) begin
         closed_in = 1'b0;
         wc_in     = wc_eff;
         case (pos_eff)
            swfc_pkg::POS_HIGH: begin
               hi_in  = s1_byte_ff;
               crc_in = crc_next;
               pos_in = swfc_pkg::POS_LOW;
            end
            swfc_pkg::POS_LOW: begin
               lo_in  = s1_byte_ff;
               crc_in = crc_next;
               pos_in = swfc_pkg::POS_CRC;
            end
            default: begin
               crc_in = swfc_pkg::CRC_INIT;
               pos_in = swfc_pkg::POS_HIGH;
               if (last) begin
                  closed_in = 1'b1;
               end else begin
                  wc_in = wc_eff + 2'd1;
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_scaled_in = rsp_scaled_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_hum_in    = rsp_hum_ff;
      rsp_last_in   = rsp_last_ff;
      if (s1_go && makes_result) begin
         rsp_valid_in  = 1'b1;
         rsp_word_in   = raw;
         rsp_index_in  = wc_eff;
         rsp_scaled_in = scale_rsp.scaled;
         rsp_err_in    = err;
         rsp_hum_in    = scale_rsp.humidity_invalid;
         rsp_last_in   = last;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff     <= swfc_pkg::WORDS_RESET;
         convert_ff   <= swfc_pkg::CONVERT_RESET;
         s1_valid_ff  <= 1'b0;
         crc_ff       <= swfc_pkg::CRC_INIT;
         pos_ff       <= swfc_pkg::POS_HIGH;
         wc_ff        <= 2'd0;
         hi_ff        <= 8'd0;
         lo_ff        <= 8'd0;
         closed_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         words_ff     <= words_in;
         convert_ff   <= convert_in;
         s1_valid_ff  <= s1_valid_in;
         crc_ff       <= crc_in;
         pos_ff       <= pos_in;
         wc_ff        <= wc_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff    <= s1_byte_in;
      s1_start_ff   <= s1_start_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_scaled_ff <= rsp_scaled_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_hum_ff    <= rsp_hum_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.word_value       = rsp_word_ff;
   assign rsp_if.word_index       = rsp_index_ff;
   assign rsp_if.scaled_value     = rsp_scaled_ff;
   assign rsp_if.crc_error        = rsp_err_ff;
   assign rsp_if.humidity_invalid = rsp_hum_ff;
   assign rsp_if.frame_last       = rsp_last_ff;

   // checks
   a_err_ends_frame : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_last_ff)
      else $error("crc error item without frame_last");

   a_hum_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hum_ff |-> (rsp_index_ff == swfc_pkg::IDX_HUM) && (rsp_scaled_ff == 0))
      else $error("humidity_invalid on wrong item");

   a_last_closes : assert property (@(posedge clock) disable iff (reset)
      s1_go && makes_result && last |=> closed_ff)
      else $error("frame not closed after last word");

   a_pos_range : assert property (@(posedge clock) disable iff (reset)
      pos_ff != 2'd3)
      else $error("byte position out of range");

   a_index_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_index_ff != 2'd3)
      else $error("word index out of range");

endmodule
